[design/slfr_pkg.sv]
// Package for the SOH/STX length frame receiver.
// Holds the shared constants, register indexes and the result and configuration types.
// No dependencies; every other design file imports it.
`default_nettype none

package slfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 2'd1;

    // Reset values of the start codes.
    localparam logic [BYTE_W-1:0] START_ONE_RST = 8'h01;
    localparam logic [BYTE_W-1:0] START_TWO_RST = 8'h02;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_one;
        logic [BYTE_W-1:0] start_two;
    } t_cfg;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_result;
        logic              checksum_good;
    } t_result;

endpackage

`default_nettype wire

[design/slfr_cfg_regs.sv]
// Configuration registers of the SOH/STX length frame receiver.
// Holds the two start codes written through the plain write port; uses slfr_pkg.
`default_nettype none

module slfr_cfg_regs
    import slfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_one <= START_ONE_RST;
            r_cfg.start_two <= START_TWO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_ONE: r_cfg.start_one <= i_cfg_data;
                REG_START_TWO: r_cfg.start_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/slfr_deframer.sv]
// Input register and frame state machine of the SOH/STX length frame receiver.
// Each registered byte is handled once the result buffer has room and may push one result; uses slfr_pkg.
`default_nettype none

module slfr_deframer
    import slfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_fire,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_buf_full,
    input  wire t_cfg              i_cfg,
    output logic                   o_push,
    output t_result                o_result
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } t_phase;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_phase            r_phase;
    logic              r_prev_one;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] r_seen;
    logic [BYTE_W-1:0] r_sum;

    t_phase            n_phase;
    logic              n_prev_one;
    logic [BYTE_W-1:0] n_len;
    logic [BYTE_W-1:0] n_seen;
    logic [BYTE_W-1:0] n_sum;
    logic              consume;
    logic              good;
    logic [BYTE_W:0]   seen_plus_two;

    assign consume       = r_in_valid && !i_buf_full;
    assign good          = (r_sum == r_in_byte);
    assign seen_plus_two = {1'b0, r_seen} + (BYTE_W+1)'(2);

    always_comb begin
        n_phase    = r_phase;
        n_prev_one = r_prev_one;
        n_len      = r_len;
        n_seen     = r_seen;
        n_sum      = r_sum;
        o_push     = 1'b0;
        o_result   = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_prev_one && (r_in_byte == i_cfg.start_two)) begin
                    n_phase    = PH_LEN;
                    n_prev_one = 1'b0;
                end else begin
                    n_prev_one = (r_in_byte == i_cfg.start_one);
                end
            end
            PH_LEN: begin
                n_len   = r_in_byte;
                n_seen  = '0;
                n_sum   = '0;
                n_phase = (r_in_byte >= BYTE_W'(2)) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                o_push                 = 1'b1;
                o_result.result_kind   = KIND_PAYLOAD;
                o_result.payload_byte  = r_in_byte;
                o_result.payload_index = r_seen;
                n_sum  = r_sum + r_in_byte;
                n_seen = r_seen + BYTE_W'(1);
                // The last payload byte is number N-1 counted from one.
                if (seen_plus_two >= {1'b0, r_len}) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_push                 = 1'b1;
                o_result.result_kind   = KIND_FRAME;
                o_result.frame_result  = good ? r_len : '0;
                o_result.checksum_good = good;
                n_phase    = PH_HUNT;
                n_prev_one = 1'b0;
                n_len      = '0;
                n_seen     = '0;
                n_sum      = '0;
            end
            default: ;
        endcase
        if (!consume) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HUNT;
            r_prev_one <= 1'b0;
            r_len      <= '0;
            r_seen     <= '0;
            r_sum      <= '0;
        end else begin
            if (i_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_phase    <= n_phase;
                r_prev_one <= n_prev_one;
                r_len      <= n_len;
                r_seen     <= n_seen;
                r_sum      <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_in_byte <= i_rx_byte;
        end
    end

    a_push_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_phase == PH_DATA || r_phase == PH_CHECK))
        else $error("result pushed outside payload or checksum phase");

    a_check_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_phase == PH_CHECK) |=> (r_phase == PH_HUNT && !r_prev_one))
        else $error("frame end did not restart hunting");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> ({1'b0, r_seen} + (BYTE_W+1)'(1) < {1'b0, r_len}))
        else $error("payload index beyond frame length");

    a_no_lost_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && i_buf_full) |=> r_in_valid)
        else $error("held byte dropped while the result buffer was full");

endmodule

`default_nettype wire

[design/slfr_out_buf.sv]
// Two-entry result buffer of the SOH/STX length frame receiver.
// An output register plus a skid entry, so the core keeps going while a result waits; uses slfr_pkg.
`default_nettype none

module slfr_out_buf
    import slfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_full,
    output logic         o_valid,
    output t_result      o_result
);

    logic [1:0] r_count;
    t_result    r_head;
    t_result    r_skid;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_result = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (pop && i_push) begin
            if (r_count == 2'd2) begin
                r_head <= r_skid;
                r_skid <= i_result;
            end else begin
                r_head <= i_result;
            end
        end else if (pop) begin
            r_head <= r_skid;
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_head <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("result pushed into a full buffer");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && pop && !i_push) |=> (r_count == 2'd1))
        else $error("buffer did not drain by one");

endmodule

`default_nettype wire

[design/soh_stx_length_frame_receiver.sv]
// Top level of the SOH/STX length frame receiver.
// Instantiates slfr_cfg_regs, slfr_deframer and slfr_out_buf; uses slfr_pkg.
//
// The receiver takes one serial byte per beat and delivers one result per
// payload byte and one per finished frame. It hunts for the start code pair
// (registers start_one and start_two, reset 0x01 and 0x02), then
// reads the length byte N, passes on N-1 payload bytes with their index, and
// compares the wrapping 8-bit sum of the payload with the sender's checksum
// byte. The frame result carries N when the sums match and 0 otherwise.
// A byte is accepted in every cycle in which the result buffer is not full:
// an accepted byte waits in the input register until the result buffer has
// room, the frame state machine then handles it, and its result is pushed
// into the result buffer. A two-entry result buffer (output register plus
// skid entry) decouples the sides, and o_stall rises only when both entries
// hold results that have not been taken.
// Start codes should be written only while the receiver is idle.
`default_nettype none

module soh_stx_length_frame_receiver
    import slfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    // Input byte channel.
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    // Result channel.
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_result_kind,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic [BYTE_W-1:0]         o_payload_index,
    output logic [BYTE_W-1:0]         o_frame_result,
    output logic                      o_checksum_good
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    core_push;
    logic    buf_full;
    logic    in_fire;

    // The stall is the registered full flag of the result buffer, so it never
    // depends on the incoming valid within the same cycle.
    assign o_stall = buf_full;
    assign in_fire = i_valid && !buf_full;

    slfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The deframer only advances when the buffer has room, so a held byte
    // waits in the input register rather than being lost.
    slfr_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_rx_byte (i_rx_byte),
        .i_buf_full(buf_full),
        .i_cfg     (cfg),
        .o_push    (core_push),
        .o_result  (core_result)
    );

    slfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_result(core_result),
        .i_stall (i_stall),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_result(out_result)
    );

    assign o_result_kind   = out_result.result_kind;
    assign o_payload_byte  = out_result.payload_byte;
    assign o_payload_index = out_result.payload_index;
    assign o_frame_result  = out_result.frame_result;
    assign o_checksum_good = out_result.checksum_good;

endmodule

`default_nettype wire

[tb/sv/slfr_result_checker.sv]
// Result checker for the SOH/STX length frame receiver testbench.
// Watches the configuration port and both beat channels, predicts the results
// and compares them. Depends on slfr_pkg.
module slfr_result_checker
    import slfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_result_kind,
    input  wire logic [BYTE_W-1:0]    i_payload_byte,
    input  wire logic [BYTE_W-1:0]    i_payload_index,
    input  wire logic [BYTE_W-1:0]    i_frame_result,
    input  wire logic                 i_checksum_good,
    output int                        o_mismatches,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        HUNTING,
        LENGTH_NEXT,
        PAYLOAD,
        CHECKSUM_NEXT
    } t_rx_phase;

    logic [BYTE_W-1:0] code_one;
    logic [BYTE_W-1:0] code_two;
    t_rx_phase         rx_phase;
    logic              after_code_one;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] bytes_taken;
    logic [BYTE_W-1:0] payload_sum;
    t_result           pending_results[$];

    initial o_mismatches = 0;
    initial o_pending = 0;

    task automatic restart_hunt();
        rx_phase       = HUNTING;
        after_code_one = 1'b0;
        frame_len      = '0;
        bytes_taken    = '0;
        payload_sum    = '0;
    endtask

    // Advances the frame state by one received byte and queues the result
    // that the byte produces, if any.
    task automatic deframe_byte(input logic [BYTE_W-1:0] rx);
        logic    sum_ok;
        t_result res;
        case (rx_phase)
            HUNTING: begin
                if (after_code_one && rx == code_two) begin
                    rx_phase       = LENGTH_NEXT;
                    after_code_one = 1'b0;
                end else begin
                    after_code_one = (rx == code_one);
                end
            end
            LENGTH_NEXT: begin
                frame_len   = rx;
                bytes_taken = '0;
                payload_sum = '0;
                rx_phase    = (rx >= 8'd2) ? PAYLOAD : CHECKSUM_NEXT;
            end
            PAYLOAD: begin
                res = '{result_kind: KIND_PAYLOAD, payload_byte: rx,
                        payload_index: bytes_taken, frame_result: '0,
                        checksum_good: 1'b0};
                pending_results.push_back(res);
                payload_sum = payload_sum + rx;
                bytes_taken = bytes_taken + 8'd1;
                if (int'(bytes_taken) + 1 >= int'(frame_len))
                    rx_phase = CHECKSUM_NEXT;
            end
            default: begin
                sum_ok = (payload_sum == rx);
                res = '{result_kind: KIND_FRAME, payload_byte: '0, payload_index: '0,
                        frame_result: sum_ok ? frame_len : 8'd0,
                        checksum_good: sum_ok};
                pending_results.push_back(res);
                restart_hunt();
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s wrong, expected %0h, actual %0h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            code_one = START_ONE_RST;
            code_two = START_TWO_RST;
            restart_hunt();
            pending_results.delete();
        end else begin
            // A result beat always belongs to a byte accepted at an earlier edge.
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h %0h",
                             $time, i_result_kind, i_payload_byte, i_payload_index,
                             i_frame_result, i_checksum_good);
                    o_mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("result_kind", 8'(want.result_kind), 8'(i_result_kind));
                    compare_field("payload_byte", want.payload_byte, i_payload_byte);
                    compare_field("payload_index", want.payload_index, i_payload_index);
                    compare_field("frame_result", want.frame_result, i_frame_result);
                    compare_field("checksum_good", 8'(want.checksum_good),
                                  8'(i_checksum_good));
                end
            end
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_rx_byte);
            // Register writes apply from the next byte on.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START_ONE: code_one = i_cfg_data;
                    REG_START_TWO: code_two = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pending_results.size();
    end

endmodule

[tb/sv/tb_soh_stx_length_frame_receiver.sv]
// Testbench top for the SOH/STX length frame receiver.
// Drives bytes, start codes and result stalls; relies on slfr_pkg,
// slfr_result_checker and the design under test.
module tb_soh_stx_length_frame_receiver;
    import slfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    // The receiver holds off this long once, so the result buffer fills
    // and the block has to stall its byte input.
    localparam int HOLD_CYCLES  = 200;
    // Cycles to let pass after the last expected result before touching the
    // start codes or ending the run.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 170;
    localparam int LIMIT_CYCLES = 600000;
    // Index values beyond the two real registers; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_result_kind;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [BYTE_W-1:0]    o_payload_index;
    logic [BYTE_W-1:0]    o_frame_result;
    logic                 o_checksum_good;

    int mismatches;
    int results_due;

    // Stimulus-side copies of the start codes, used to build frames.
    logic [BYTE_W-1:0] cur_one;
    logic [BYTE_W-1:0] cur_two;
    int                bytes_sent;
    int                burst_left;
    logic              hold_request;

    soh_stx_length_frame_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_result  (o_frame_result),
        .o_checksum_good (o_checksum_good)
    );

    slfr_result_checker result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_result_kind   (o_result_kind),
        .i_payload_byte  (o_payload_byte),
        .i_payload_index (o_payload_index),
        .i_frame_result  (o_frame_result),
        .i_checksum_good (o_checksum_good),
        .o_mismatches    (mismatches),
        .o_pending       (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Frame lengths: mostly short frames, with the short-length cases and a
    // few longer frames mixed in.
    function automatic logic [BYTE_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'($urandom_range(0, 1));
        if (r < 80) return 8'($urandom_range(2, 12));
        if (r < 97) return 8'($urandom_range(13, 40));
        return 8'($urandom_range(41, 90));
    endfunction

    // Offers one byte, after an optional gap, and returns at the rising edge
    // where the beat is taken. Valid stays high into the next byte when no gap
    // follows, so there is never a drop and rise within one time step.
    task automatic push_byte(input logic [BYTE_W-1:0] rx);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 29) == 0) begin
            gap = 0;
            burst_left = $urandom_range(20, 60);
        end else begin
            gap = pick_gap();
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_rx_byte = rx;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    // Lowers valid and waits until every expected result has come, then a
    // little longer, since hunting and length bytes produce nothing.
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // A well-formed frame with random payload; the checksum is either the
    // true wrapping sum or something guaranteed to differ from it.
    task automatic send_frame(input logic [BYTE_W-1:0] len, input bit intact);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] data;
        sum = '0;
        push_byte(cur_one);
        push_byte(cur_two);
        push_byte(len);
        for (int k = 1; k < int'(len); k++) begin
            data = 8'($urandom_range(0, 255));
            sum  = sum + data;
            push_byte(data);
        end
        push_byte(intact ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    // Line noise, leaning toward the first start code so that lone and
    // repeated start bytes show up often.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(0, 3) == 0) ? cur_one : 8'($urandom_range(0, 255)));
    endtask

    // A frame cut short: the next frame's bytes land in its payload.
    task automatic send_cut_frame();
        logic [BYTE_W-1:0] len;
        len = 8'($urandom_range(8, 30));
        push_byte(cur_one);
        push_byte(cur_two);
        push_byte(len);
        repeat ($urandom_range(0, int'(len) - 2)) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_mix(input int count);
        int stop_at;
        int r;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_frame(pick_length(), $urandom_range(0, 3) != 0);
            end else if (r < 78) begin
                repeat ($urandom_range(1, 4)) push_byte(cur_one);
                send_frame(pick_length(), 1'($urandom_range(0, 1)));
            end else if (r < 93) begin
                send_noise();
            end else begin
                send_cut_frame();
            end
        end
    endtask

    // Result side: random stall runs, plus one long counted hold-off when
    // the stimulus asks for it.
    initial begin
        i_stall = 1'b0;
        forever begin
            if (hold_request) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
                hold_request = 1'b0;
            end else begin
                repeat ($urandom_range(1, 40)) begin
                    @(negedge i_clk);
                    i_stall = 1'b0;
                end
                repeat (pick_gap()) begin
                    @(negedge i_clk);
                    i_stall = 1'b1;
                end
            end
        end
    end

    // Watchdog: a hang or lost result ends the run as a failure.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] opening[$];
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_byte    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_START_ONE;
        i_cfg_data   = '0;
        hold_request = 1'b0;
        burst_left   = 0;
        bytes_sent   = 0;
        cur_one      = START_ONE_RST;
        cur_two      = START_TWO_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed bytes with the reset start codes. In order: a zero-length
        // frame with a matching checksum, a run of first start bytes before a
        // length-one frame with a bad checksum, a three-byte frame whose
        // payload 0xff + 0x01 wraps to zero, a length-one frame whose checksum
        // equals the first start code and is followed by the second one (that
        // must not open a frame), and finally a good two-byte frame.
        opening = '{8'h01, 8'h02, 8'h00, 8'h00,
                    8'h01, 8'h01, 8'h02, 8'h01, 8'h07,
                    8'h01, 8'h02, 8'h03, 8'hff, 8'h01, 8'h00,
                    8'h01, 8'h02, 8'h01, 8'h01, 8'h02,
                    8'h01, 8'h02, 8'h02, 8'h7f, 8'h7f};
        foreach (opening[k]) push_byte(opening[k]);

        // Random phases, each with its own pair of start codes: the extremes,
        // equal codes, random codes and the reset values again.
        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: begin cur_one = 8'h00; cur_two = 8'hff; end
                1: begin cur_one = 8'hff; cur_two = 8'hff; end
                2: begin cur_one = 8'haa; cur_two = 8'haa; end
                3: begin
                    cur_one = 8'($urandom_range(0, 255));
                    cur_two = 8'($urandom_range(0, 255));
                end
                default: begin cur_one = START_ONE_RST; cur_two = START_TWO_RST; end
            endcase
            write_reg(REG_START_ONE, cur_one);
            write_reg(REG_START_TWO, cur_two);
            if (p == 2) begin
                write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
                write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
            end
            if (p == 0) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            // The longest frame the length byte allows, once.
            if (p == 1) send_frame(8'hff, 1'b1);
            send_mix(PHASE_BYTES);
        end
        settle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
